@@ rtl/ppgdc_pkg.sv @@
package ppgdc_pkg;

  localparam int SAMPLE_BITS = 18;
  localparam int Q_BITS      = 15;
  localparam int DC_W        = 34;
  localparam int AC_W        = SAMPLE_BITS + 1;
  localparam int OUT_W       = 24;

  localparam int HALF_TAPS   = 11;
  localparam int SPAN        = 2 * HALF_TAPS;
  localparam int NUM_TAPS    = SPAN + 1;
  localparam int WT_W        = 13;
  localparam int PRE_W       = AC_W + 1;
  localparam int PROD_W      = PRE_W + WT_W + 1;
  localparam int ACC_W       = 36;
  localparam int GROUP_SIZE  = 3;
  localparam int NUM_GROUPS  = (HALF_TAPS + 1) / GROUP_SIZE;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WT_W-1:0] TAP_WEIGHT [HALF_TAPS+1] = '{
    13'd172, 13'd321, 13'd579, 13'd927, 13'd1360, 13'd1858,
    13'd2390, 13'd2916, 13'd3391, 13'd3768, 13'd4012, 13'd4096
  };

  typedef logic signed [AC_W-1:0]  ac_t;
  typedef logic signed [OUT_W-1:0] out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/ppgdc_front.sv @@
module ppgdc_front #(
  parameter int DC_SHIFT = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ppgdc_pkg::SAMPLE_BITS-1:0]  in_raw_sample,
  input  ppgdc_pkg::q_stat_t                 q_stat,
  output logic                               push,
  output ppgdc_pkg::ac_t                     push_data
);
  import ppgdc_pkg::*;

  logic                       f1_valid_r, f1_valid_nxt;
  logic [SAMPLE_BITS-1:0]     sample_r;
  logic signed [DC_W-1:0]     dc_r, dc_nxt;
  logic signed [DC_W:0]       target, diff, step;
  logic signed [DC_W-1:0]     level;
  logic                       accept;

  assign in_stall = f1_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = f1_valid_r && !q_stat.full;

  // leaky integrator toward sample in q15
  always_comb begin
    target = $signed({2'b00, in_raw_sample, {Q_BITS{1'b0}}});
    diff   = target - $signed({dc_r[DC_W-1], dc_r});
    step   = diff >>> DC_SHIFT;
    dc_nxt = dc_r + step[DC_W-1:0];
  end

  // dc_r already holds the level that belongs to sample_r
  always_comb begin
    level     = dc_r >>> Q_BITS;
    push_data = $signed({1'b0, sample_r}) - level[AC_W-1:0];
  end

  always_comb begin
    f1_valid_nxt = f1_valid_r;
    if (accept) begin
      f1_valid_nxt = 1'b1;
    end else if (push) begin
      f1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      dc_r       <= '0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
      if (accept) begin
        dc_r <= dc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_raw_sample;
    end
  end

endmodule

@@ rtl/ppgdc_queue.sv @@
module ppgdc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ppgdc_pkg::ac_t     push_data,
  input  logic               pop,
  output ppgdc_pkg::ac_t     pop_data,
  output ppgdc_pkg::q_stat_t q_stat
);
  import ppgdc_pkg::*;

  ac_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/ppgdc_back.sv @@
module ppgdc_back #(
  parameter int OUTPUT_SHIFT = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ppgdc_pkg::q_stat_t q_stat,
  input  ppgdc_pkg::ac_t     pop_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ppgdc_pkg::out_t    out_filtered_ac
);
  import ppgdc_pkg::*;

  localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(2**(OUT_W-1) - 1);
  localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - 1;

  logic                       en;
  ac_t                        taps_r [NUM_TAPS];
  logic                       v0_r, v1_r, v2_r, v3_r;
  logic signed [ACC_W-1:0]    prod_r [HALF_TAPS+1];
  logic signed [ACC_W-1:0]    grp_r  [NUM_GROUPS];
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  out_t                       out_data_r;

  logic signed [PRE_W-1:0]    presum [HALF_TAPS+1];
  logic signed [PROD_W-1:0]   prod_c [HALF_TAPS+1];
  logic signed [ACC_W-1:0]    grp_c  [NUM_GROUPS];
  logic signed [ACC_W-1:0]    acc_c;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [ACC_W:0]      negated;
  out_t                       sat_c;

  // whole back pipeline moves together when the output can take a request
  assign en              = !out_valid_r || !out_stall;
  assign pop             = en && !q_stat.empty;
  assign out_valid       = out_valid_r;
  assign out_filtered_ac = out_data_r;

  // folded symmetric taps, constant multiplies
  always_comb begin
    for (int i = 0; i < HALF_TAPS; i++) begin
      presum[i] = PRE_W'(taps_r[i]) + PRE_W'(taps_r[SPAN-i]);
    end
    presum[HALF_TAPS] = PRE_W'(taps_r[HALF_TAPS]);
    for (int i = 0; i <= HALF_TAPS; i++) begin
      prod_c[i] = presum[i] * $signed({1'b0, TAP_WEIGHT[i]});
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_c[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        grp_c[g] = grp_c[g] + prod_r[g*GROUP_SIZE + k];
      end
    end
    acc_c = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      acc_c = acc_c + grp_r[g];
    end
  end

  always_comb begin
    shifted = acc_r >>> OUTPUT_SHIFT;
    negated = -(ACC_W+1)'(shifted);
    if (negated > SAT_HI) begin
      sat_c = SAT_HI[OUT_W-1:0];
    end else if (negated < SAT_LO) begin
      sat_c = SAT_LO[OUT_W-1:0];
    end else begin
      sat_c = negated[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        taps_r[i] <= '0;
      end
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      if (pop) begin
        taps_r[0] <= pop_data;
        for (int i = 1; i < NUM_TAPS; i++) begin
          taps_r[i] <= taps_r[i-1];
        end
      end
      v0_r        <= pop;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= HALF_TAPS; i++) begin
        prod_r[i] <= ACC_W'(prod_c[i]);
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_r[g] <= grp_c[g];
      end
      acc_r <= acc_c;
      if (v3_r) begin
        out_data_r <= sat_c;
      end
    end
  end

endmodule

@@ rtl/ppg_dc_removal_fir_lowpass_top.sv @@
// throughput: one request per cycle while in_stall is low; the dc accumulator updates
// on each accepted request, and the fir runs as a pipeline of tap history, product, group
// sum, accumulator and output registers behind a two-entry queue
// reset (rst_n low, synchronous): dc level, 23-sample history and all valids cleared
module ppg_dc_removal_fir_lowpass_top #(
  parameter int DC_SHIFT     = 4,
  parameter int OUTPUT_SHIFT = 11
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ppgdc_pkg::SAMPLE_BITS-1:0]  in_raw_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ppgdc_pkg::out_t                    out_filtered_ac
);
  import ppgdc_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  ac_t     push_data;
  ac_t     pop_data;

  ppgdc_front #(
    .DC_SHIFT(DC_SHIFT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_sample (in_raw_sample),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  ppgdc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  ppgdc_back #(
    .OUTPUT_SHIFT(OUTPUT_SHIFT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop_data        (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_filtered_ac (out_filtered_ac)
  );

endmodule

@@ tb/tb_ppg_dc_removal_fir_lowpass_top.sv @@
`timescale 1ns / 1ps

module tb_ppg_dc_removal_fir_lowpass_top;
  import ppgdc_pkg::*;

  localparam int HIST_DEPTH   = 32;
  localparam int DC_SHIFT     = 4;
  localparam int OUT_SHIFT    = 11;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int RANDOM_ITEMS = 1600;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_DIRECTED = 20;
  localparam longint SAT_HI   = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint SAT_LO   = -(longint'(1) <<< (OUT_W - 1));
  localparam int FIR_COEF [12] = '{172, 321, 579, 927, 1360, 1858,
                                   2390, 2916, 3391, 3768, 4012, 4096};

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {SEG_UNIFORM, SEG_PULSE, SEG_EXTREME, SEG_RAMP} seg_mode_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   known;
    logic [OUT_W-1:0]       result;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_raw_sample;
  logic                   out_valid;
  logic                   out_stall;
  out_t                   out_filtered_ac;

  // predictor state
  longint         dc_acc;
  longint         ac_hist [HIST_DEPTH];
  logic [4:0]     hist_wr;

  out_t           pending_outputs [$];
  out_t           want;
  int             mismatch_count;
  int             cycle_count;
  int             hold_trigger;
  stim_row_t      directed_rows [NUM_DIRECTED];

  // random sample segments
  seg_mode_t      seg_mode;
  int             seg_left;
  int             seg_base;
  int             seg_step;

  ppg_dc_removal_fir_lowpass_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_sample   (in_raw_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_filtered_ac (out_filtered_ac)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint hist_back(int k);
    logic [4:0] idx;
    idx = hist_wr - 5'(k);
    return ac_hist[idx];
  endfunction

  // dc tracking, ac history and symmetric fir, one sample at a time
  function automatic out_t filter_sample(logic [SAMPLE_BITS-1:0] s);
    longint sample;
    longint level;
    longint acc;
    longint y;
    sample = longint'(s);
    dc_acc = dc_acc + (((sample <<< Q_BITS) - dc_acc) >>> DC_SHIFT);
    level = dc_acc >>> Q_BITS;
    ac_hist[hist_wr] = sample - level;
    acc = FIR_COEF[HALF_TAPS] * hist_back(HALF_TAPS);
    for (int i = 0; i < HALF_TAPS; i++) begin
      acc += FIR_COEF[i] * (hist_back(i) + hist_back(SPAN - i));
    end
    hist_wr = hist_wr + 5'd1;
    y = -(acc >>> OUT_SHIFT);
    if (y > SAT_HI) y = SAT_HI;
    if (y < SAT_LO) y = SAT_LO;
    return out_t'(y);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] next_sample();
    int v;
    if (seg_left == 0) begin
      seg_mode = seg_mode_t'($urandom_range(0, 3));
      seg_left = $urandom_range(16, 120);
      seg_base = $urandom_range(0, SAMPLE_MAX);
      seg_step = int'($urandom_range(0, 4000)) - 2000;
    end
    seg_left--;
    case (seg_mode)
      SEG_UNIFORM: v = $urandom_range(0, SAMPLE_MAX);
      SEG_PULSE:   v = seg_base + int'($urandom_range(0, 1023)) - 512;
      SEG_EXTREME: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      default: begin
        seg_base = seg_base + seg_step;
        if (seg_base < 0) seg_base = 0;
        if (seg_base > SAMPLE_MAX) seg_base = SAMPLE_MAX;
        v = seg_base;
      end
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  task automatic note_mismatch(string what, out_t exp_val, out_t got_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s: expected %0d, got %0d", what, exp_val, got_val);
    end
  endtask

  // one request, held until accepted
  task automatic send_sample(logic [SAMPLE_BITS-1:0] s, logic known, out_t typed);
    out_t predicted;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_raw_sample <= s;
    do @(posedge clk); while (in_stall);
    predicted = filter_sample(s);
    pending_outputs.push_back(known ? typed : predicted);
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle(1);
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        note_mismatch("unexpected result", '0, out_filtered_ac);
      end else begin
        want = pending_outputs.pop_front();
        if (out_filtered_ac !== want) note_mismatch("filtered_ac", want, out_filtered_ac);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  initial begin
    int          hold_seen;
    int          hold_left;
    int          phase_left;
    int          stall_tick;
    stall_mode_t stall_style;
    hold_seen   = 0;
    hold_left   = 0;
    phase_left  = 0;
    stall_tick  = 0;
    stall_style = STALL_NONE;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          stall_style = stall_mode_t'($urandom_range(0, 3));
          phase_left  = $urandom_range(20, 200);
        end
        phase_left--;
        stall_tick++;
        case (stall_style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
          default:     out_stall <= ((stall_tick % 5) >= 2);
        endcase
      end
    end
  end

  initial begin
    int burst_left;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_raw_sample  = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    hold_trigger   = 0;
    dc_acc         = 0;
    hist_wr        = '0;
    seg_mode       = SEG_UNIFORM;
    seg_left       = 0;
    seg_base       = 0;
    seg_step       = 0;
    burst_left     = 0;
    foreach (ac_hist[i]) ac_hist[i] = 0;

    // zeros after reset give zero; a first full-scale sample gives -(172*245760 >> 11)
    directed_rows = '{
      '{18'd0,      1'b1, 24'd0},
      '{18'd0,      1'b1, 24'd0},
      '{18'd0,      1'b1, 24'd0},
      '{18'd262143, 1'b1, -24'sd20640},
      '{18'd262143, 1'b0, 24'd0},
      '{18'd262143, 1'b0, 24'd0},
      '{18'd262143, 1'b0, 24'd0},
      '{18'd0,      1'b0, 24'd0},
      '{18'd0,      1'b0, 24'd0},
      '{18'd262143, 1'b0, 24'd0},
      '{18'd0,      1'b0, 24'd0},
      '{18'd262143, 1'b0, 24'd0},
      '{18'd0,      1'b0, 24'd0},
      '{18'd1,      1'b0, 24'd0},
      '{18'd131072, 1'b0, 24'd0},
      '{18'd131071, 1'b0, 24'd0},
      '{18'h2AAAA,  1'b0, 24'd0},
      '{18'h15555,  1'b0, 24'd0},
      '{18'd262142, 1'b0, 24'd0},
      '{18'd262143, 1'b0, 24'd0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].sample, directed_rows[i].known,
                  out_t'(directed_rows[i].result));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // long receiver hold-off while requests keep coming
      if (n == 400 || n == 1200) hold_trigger++;
      if (n == 800) wait_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
      end
      burst_left--;
      send_sample(next_sample(), 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
